[src/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// Seven-segment scan driver package
// Shared constants, control and status types and the segment decode.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int VALUE_W     = 32;
    localparam int BCD_W       = 4 * DIGIT_COUNT;
    localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int CNT_W       = $clog2(VALUE_W);
    localparam int SEG_W       = 8;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

    // Action field of an input word.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the binary word, clear the BCD register
        logic shift;   // one shift-add-3 step
        logic commit;  // copy the BCD digits into the digit store
        logic tick;    // build one scan word into the output register
    } ssd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
    } ssd_status_t;

    // abcdefg pattern, a in the top bit.
    function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
        logic [6:0] pattern;
        unique case (digit)
            4'd0:    pattern = 7'b1111110;
            4'd1:    pattern = 7'b0110000;
            4'd2:    pattern = 7'b1101101;
            4'd3:    pattern = 7'b1111001;
            4'd4:    pattern = 7'b0110011;
            4'd5:    pattern = 7'b1011011;
            4'd6:    pattern = 7'b0011111;
            4'd7:    pattern = 7'b1110000;
            4'd8:    pattern = 7'b1111111;
            4'd9:    pattern = 7'b1110011;
            default: pattern = 7'b1010101;
        endcase
        return pattern;
    endfunction

endpackage

[src/ssd_ctrl.sv]
// ----------------------------------------------------------------------------
// Seven-segment scan driver controller
// Accepts words, sequences the binary-to-BCD conversion of a load.
// ----------------------------------------------------------------------------
module ssd_ctrl
    import ssd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_action,
    input  logic        m_tready,
    input  ssd_status_t status,
    output ssd_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CONV   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE) && (!status.out_valid || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_TICK) begin
                        cmd.tick = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[src/ssd_datapath.sv]
// ----------------------------------------------------------------------------
// Seven-segment scan driver datapath
// Shift-add-3 converter, digit store, scan position and output register.
// ----------------------------------------------------------------------------
module ssd_datapath
    import ssd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  ssd_cmd_t           cmd,
    output ssd_status_t        status,
    input  logic [VALUE_W-1:0] value,
    input  logic               m_tready,
    output logic               out_valid,
    output logic [SEG_W-1:0]   segments,
    output logic [SEG_W-1:0]   digit_select
);

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         store_reg [DIGIT_COUNT];
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               out_valid_reg;
    logic [SEG_W-1:0]   seg_reg, seg_next;
    logic [SEG_W-1:0]   sel_reg, sel_next;

    // Digits above the kept ones are shifted out; corrections only carry
    // upward, so the kept digits are still exact.
    always_comb begin
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            if (bcd_reg[4*k +: 4] >= 4'd5) begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            end else begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
            end
        end
        bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
        bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bin_reg <= value;
            bcd_reg <= '0;
        end else if (cmd.shift) begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    // Position 0 holds the most significant kept digit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                store_reg[i] <= '0;
            end
        end else if (cmd.commit) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                store_reg[i] <= bcd_reg[4*(DIGIT_COUNT-1-i) +: 4];
            end
        end
    end

    always_comb begin
        pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
        seg_next = {seg_pattern(store_reg[pos_reg]), 1'b0};
        for (int b = 0; b < SEG_W; b++) begin
            sel_next[b] = (b != (DIGIT_COUNT - 1 - int'(pos_reg)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.tick) begin
                pos_reg       <= pos_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick) begin
            seg_reg <= seg_next;
            sel_reg <= sel_next;
        end
    end

    assign status.out_valid = out_valid_reg;
    assign out_valid        = out_valid_reg;
    assign segments         = seg_reg;
    assign digit_select     = sel_reg;

endmodule

[src/seven_segment_scan_driver.sv]
// A scan tick word is registered and shown on m_tdata in the cycle after it is taken.
// A load word runs through the converter loop (capture, 32 shift-add-3 steps,
// store write); no word is taken while it runs. While a result waits, the
// next word is taken only in the cycle that the waiting result is taken.
// Reset (aresetn low, synchronous) clears the digit store, the scan position
// and the output valid flag.
// ----------------------------------------------------------------------------
// Seven-segment scan driver top level
// Eight-digit multiplexed display driver with binary-to-decimal loading.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver
    import ssd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
    input  logic               s_tuser,   // [0] action
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata    // [7:0] segments, [15:8] digit_select
);

    ssd_cmd_t    cmd;
    ssd_status_t status;
    logic [SEG_W-1:0] segments;
    logic [SEG_W-1:0] digit_select;

    ssd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssd_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .value        (s_tdata),
        .m_tready     (m_tready),
        .out_valid    (m_tvalid),
        .segments     (segments),
        .digit_select (digit_select)
    );

    assign m_tdata = {digit_select, segments};

`ifndef SYNTHESIS
    // A taken scan tick always leaves a word in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> m_tvalid)
        else $error("scan tick produced no output word");

    // A load keeps the input side closed during the conversion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("word taken during conversion");

    // At most one digit is selected.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones(~m_tdata[15:8]) <= 1)
        else $error("more than one digit selected");

    // The decimal point is never lit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[0])
        else $error("decimal point set");
`endif

endmodule

[tb/seven_segment_scan_checker.sv]
// ----------------------------------------------------------------------------
// Seven-segment scan driver checker
// Watches both stream channels and keeps its own copy of the digit store and
// the scan position. Each accepted tick word queues the segment and select
// byte it must produce. Each result word is compared with the oldest entry.
// ----------------------------------------------------------------------------
module seven_segment_scan_checker
    import ssd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
    input  logic               s_tuser,   // [0] action
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [15:0]        m_tdata,   // [7:0] segments, [15:8] digit_select
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] digit_select;
        logic [7:0] segments;
    } scan_word_t;

    // Segment patterns abcdefg for the decimal digits, a in bit 6.
    localparam logic [6:0] DIGIT_GLYPH [0:9] = '{
        7'b1111110, 7'b0110000, 7'b1101101, 7'b1111001, 7'b0110011,
        7'b1011011, 7'b0011111, 7'b1110000, 7'b1111111, 7'b1110011
    };
    localparam logic [6:0] BAD_GLYPH = 7'b1010101;

    logic [3:0]       shown_digits [DIGIT_COUNT];
    logic [POS_W-1:0] scan_pos;
    scan_word_t       expected_scans [$];
    int               errors;

    initial begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            shown_digits[i] = 4'd0;
        end
        scan_pos   = '0;
        errors     = 0;
        fail_count = 0;
        pending    = 0;
    end

    function automatic scan_word_t predict_scan(input logic [3:0] digit,
                                                input logic [POS_W-1:0] pos);
        scan_word_t w;
        w.segments     = {(digit <= 4'd9) ? DIGIT_GLYPH[digit] : BAD_GLYPH, 1'b0};
        w.digit_select = ~(8'd1 << (DIGIT_COUNT - 1 - int'(pos)));
        return w;
    endfunction

    always @(posedge aclk) begin
        scan_word_t   want;
        scan_word_t   got;
        logic [31:0]  num;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_scans.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    errors++;
                end else begin
                    want = expected_scans.pop_front();
                    if (got.segments !== want.segments) begin
                        $display("%0t: segments expected %h actual %h",
                                 $time, want.segments, got.segments);
                        errors++;
                    end
                    if (got.digit_select !== want.digit_select) begin
                        $display("%0t: digit_select expected %h actual %h",
                                 $time, want.digit_select, got.digit_select);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == ACT_TICK) begin
                    expected_scans.push_back(predict_scan(shown_digits[scan_pos], scan_pos));
                    scan_pos = (scan_pos == POS_W'(DIGIT_COUNT - 1)) ? '0 : scan_pos + 1'b1;
                end else begin
                    // Keep the lowest decimal digits, most significant first.
                    num = s_tdata;
                    for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
                        shown_digits[i] = 4'(num % 10);
                        num = num / 10;
                    end
                end
            end
        end
        fail_count <= errors;
        pending    <= expected_scans.size();
    end

endmodule

[tb/seven_segment_scan_driver_tb.sv]
// ----------------------------------------------------------------------------
// Seven-segment scan driver testbench
// Drives load and scan tick words with random gaps and output stalls, and
// lets the checker predict and compare every segment and select word.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_tb
    import ssd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   RAND_WORDS = 900;
    localparam int   CALM_FROM  = 780;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata  = '0;
    logic               s_tuser  = ACT_LOAD;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [15:0]        m_tdata;
    int                 fail_count;
    int                 pending;
    bit                 calm     = 1'b0;
    int                 stall_left = 0;

    always #4 aclk = ~aclk;

    seven_segment_scan_driver u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    seven_segment_scan_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Output back-pressure in short bursts, switched off near the end.
    always @(negedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(1, 3) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic action, input logic [VALUE_W-1:0] value);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = action;
        s_tdata  = value;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++) begin
            send_word(ACT_TICK, $urandom);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 999);
            1:       return $urandom_range(0, 99_999_999);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int guard;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Reset contents on every position, then the largest input value.
        send_ticks(8);
        send_word(ACT_LOAD, 32'hFFFF_FFFF);
        send_ticks(8);
        send_word(ACT_LOAD, 32'd12_345_678);
        send_ticks(3);
        // Load in the middle of a scan, with digits above the eighth dropped.
        send_word(ACT_LOAD, 32'd100_012_345);
        send_ticks(5);

        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n == CALM_FROM) begin
                calm = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) begin
                send_word(ACT_LOAD, pick_value());
            end else begin
                send_word(ACT_TICK, $urandom);
            end
        end
        s_tvalid = 1'b0;

        guard = 0;
        while (pending != 0 && guard < 10_000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (40) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
